// ===== hdl/tfc_pkg.sv =====
// Package for the triangle frustum cull block.
// Holds widths, register indexes, the verdict codes and default parameter values.
// No dependencies.
package tfc_pkg;

  localparam int INDEX_BITS       = 32;
  localparam int VERTEX_BITS      = 48;
  localparam int CFG_DATA_BITS    = 64;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int PLANE_COUNT_BITS = 3;
  localparam int NORMAL_BITS      = 16;
  localparam int OFFSET_BITS      = 16;
  localparam int OFFSET_SHIFT     = 14;

  localparam int PLANE_SLOTS_DEFAULT = 6;
  localparam int COORD_BITS_DEFAULT  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_BASE   = 3'd2;

  localparam logic [PLANE_COUNT_BITS-1:0] PLANE_COUNT_RESET = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_VISIBLE = 2'd0,
    VERDICT_SKIPPED = 2'd1,
    VERDICT_CULLED  = 2'd2
  } verdict_t;

endpackage

// ===== hdl/tfc_tri_if.sv =====
// Input channel of the triangle frustum cull block: one triangle per word.
// Depends on tfc_pkg.
interface tfc_tri_if;
  import tfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [INDEX_BITS-1:0]  first_index;
  logic [INDEX_BITS-1:0]  second_index;
  logic [INDEX_BITS-1:0]  third_index;
  logic [VERTEX_BITS-1:0] first_vertex;
  logic [VERTEX_BITS-1:0] second_vertex;
  logic [VERTEX_BITS-1:0] third_vertex;
  logic                   mesh_last;

  modport source (
    output valid, first_index, second_index, third_index,
    output first_vertex, second_vertex, third_vertex, mesh_last,
    input  ready
  );

  modport sink (
    input  valid, first_index, second_index, third_index,
    input  first_vertex, second_vertex, third_vertex, mesh_last,
    output ready
  );

endinterface

// ===== hdl/tfc_res_if.sv =====
// Output channel of the triangle frustum cull block: one verdict per word.
// Depends on tfc_pkg.
interface tfc_res_if;
  import tfc_pkg::*;

  logic                  valid;
  logic                  ready;
  verdict_t              verdict;
  logic [INDEX_BITS-1:0] out_first_index;
  logic [INDEX_BITS-1:0] out_second_index;
  logic [INDEX_BITS-1:0] out_third_index;
  logic                  mesh_end;

  modport source (
    output valid, verdict, out_first_index, out_second_index, out_third_index, mesh_end,
    input  ready
  );

  modport sink (
    input  valid, verdict, out_first_index, out_second_index, out_third_index, mesh_end,
    output ready
  );

endinterface

// ===== hdl/triangle_frustum_cull.sv =====
// Triangle frustum cull: four-stage pipeline, one triangle per clock.
// An accepted input word passes the stage registers one to four before its
// result word is valid. Throughput is one word per cycle; the whole pipeline
// holds while the output register is full and not taken. Reset clears the
// valid bits and loads the configuration registers with their reset values.
// Depends on tfc_pkg and the channel interfaces tfc_tri_if and tfc_res_if.
module triangle_frustum_cull #(
  parameter int PLANE_SLOTS = tfc_pkg::PLANE_SLOTS_DEFAULT,
  parameter int COORD_BITS  = tfc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  tfc_tri_if.sink                             tri_in,
  tfc_res_if.source                           res_out
);
  import tfc_pkg::*;

  localparam int EXT_BITS  = (3 * COORD_BITS > VERTEX_BITS) ? 3 * COORD_BITS : VERTEX_BITS;
  localparam int PROD_BITS = NORMAL_BITS + COORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 4;
  localparam int OFS_BITS  = OFFSET_BITS + OFFSET_SHIFT + 2;
  localparam int DIST_BITS = (SUM_BITS > OFS_BITS) ? SUM_BITS : OFS_BITS;

  logic [INDEX_BITS-1:0]       vertex_count;
  logic [PLANE_COUNT_BITS-1:0] plane_count;
  logic [CFG_DATA_BITS-1:0]    plane_coeffs [PLANE_SLOTS];

  logic advance;

  logic                         vld1;
  logic                         bad1;
  logic [INDEX_BITS-1:0]        idx1 [3];
  logic                         last1;
  logic signed [COORD_BITS-1:0] crd1 [3][3];

  logic                        vld2;
  logic                        bad2;
  logic [INDEX_BITS-1:0]       idx2 [3];
  logic                        last2;
  logic signed [PROD_BITS-1:0] prod2 [PLANE_SLOTS][3][3];

  logic                  vld3;
  logic                  bad3;
  logic [INDEX_BITS-1:0] idx3 [3];
  logic                  last3;
  logic [PLANE_SLOTS-1:0] cull3;
  logic [PLANE_SLOTS-1:0] cull3_next;

  logic                  vld4;
  verdict_t              verdict4;
  logic [INDEX_BITS-1:0] idx4 [3];
  logic                  last4;

  logic [EXT_BITS-1:0] vert_ext [3];
  logic [PLANE_COUNT_BITS-1:0] planes_used;

  assign advance     = !vld4 || res_out.ready;
  assign tri_in.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      plane_count  <= PLANE_COUNT_RESET;
      for (int p = 0; p < PLANE_SLOTS; p++) begin
        plane_coeffs[p] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_VERTEX_COUNT) begin
        vertex_count <= cfg_data[INDEX_BITS-1:0];
      end
      if (cfg_index == REG_PLANE_COUNT) begin
        plane_count <= cfg_data[PLANE_COUNT_BITS-1:0];
      end
      for (int p = 0; p < PLANE_SLOTS; p++) begin
        if (cfg_index == REG_PLANE_BASE + CFG_INDEX_BITS'(p)) begin
          plane_coeffs[p] <= cfg_data;
        end
      end
    end
  end

  assign vert_ext[0] = EXT_BITS'(tri_in.first_vertex);
  assign vert_ext[1] = EXT_BITS'(tri_in.second_vertex);
  assign vert_ext[2] = EXT_BITS'(tri_in.third_vertex);

  // Stage one: index check and coordinate extraction (x, y, z).
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (advance) begin
      vld1 <= tri_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bad1 <= (tri_in.first_index >= vertex_count) || (tri_in.second_index >= vertex_count)
              || (tri_in.third_index >= vertex_count);
      idx1[0] <= tri_in.first_index;
      idx1[1] <= tri_in.second_index;
      idx1[2] <= tri_in.third_index;
      last1   <= tri_in.mesh_last;
      for (int v = 0; v < 3; v++) begin
        crd1[v][0] <= $signed(vert_ext[v][2*COORD_BITS +: COORD_BITS]);
        crd1[v][1] <= $signed(vert_ext[v][COORD_BITS +: COORD_BITS]);
        crd1[v][2] <= $signed(vert_ext[v][0 +: COORD_BITS]);
      end
    end
  end

  // Stage two: one product per plane, corner and axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (advance) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bad2  <= bad1;
      idx2  <= idx1;
      last2 <= last1;
      for (int p = 0; p < PLANE_SLOTS; p++) begin
        for (int v = 0; v < 3; v++) begin
          for (int k = 0; k < 3; k++) begin
            prod2[p][v][k] <= $signed(plane_coeffs[p][CFG_DATA_BITS-1-NORMAL_BITS*k -: NORMAL_BITS])
                              * crd1[v][k];
          end
        end
      end
    end
  end

  // Stage three: distances, sign test and per-plane cull flag.
  assign planes_used = (plane_count > PLANE_COUNT_BITS'(PLANE_SLOTS))
                       ? PLANE_COUNT_BITS'(PLANE_SLOTS) : plane_count;

  always_comb begin
    logic signed [DIST_BITS-1:0] distance;
    logic signed [DIST_BITS-1:0] offset;
    logic [2:0]                  behind;
    for (int p = 0; p < PLANE_SLOTS; p++) begin
      offset = {{(DIST_BITS-OFFSET_BITS-OFFSET_SHIFT){plane_coeffs[p][OFFSET_BITS-1]}},
                plane_coeffs[p][OFFSET_BITS-1:0], {OFFSET_SHIFT{1'b0}}};
      for (int v = 0; v < 3; v++) begin
        distance = offset;
        for (int k = 0; k < 3; k++) begin
          distance = distance
                     + {{(DIST_BITS-PROD_BITS){prod2[p][v][k][PROD_BITS-1]}}, prod2[p][v][k]};
        end
        behind[v] = distance[DIST_BITS-1];
      end
      cull3_next[p] = (PLANE_COUNT_BITS'(p) < planes_used) && (&behind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (advance) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bad3  <= bad2;
      idx3  <= idx2;
      last3 <= last2;
      cull3 <= cull3_next;
    end
  end

  // Stage four: verdict and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (advance) begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last4 <= last3;
      if (bad3) begin
        verdict4 <= VERDICT_SKIPPED;
        idx4     <= '{default: '0};
      end else if (|cull3) begin
        verdict4 <= VERDICT_CULLED;
        idx4     <= '{default: '0};
      end else begin
        verdict4 <= VERDICT_VISIBLE;
        idx4     <= idx3;
      end
    end
  end

  assign res_out.valid            = vld4;
  assign res_out.verdict          = verdict4;
  assign res_out.out_first_index  = idx4[0];
  assign res_out.out_second_index = idx4[1];
  assign res_out.out_third_index  = idx4[2];
  assign res_out.mesh_end         = last4;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the triangle frustum cull block.
// Drives triangle words and register writes, predicts every verdict word in a
// scoreboard class and checks the block's output in order. Depends on tfc_pkg,
// tfc_tri_if, tfc_res_if and triangle_frustum_cull.
`timescale 1ns / 100ps

module testbench;
  import tfc_pkg::*;

  localparam int PLANES = PLANE_SLOTS_DEFAULT;
  localparam int CB     = COORD_BITS_DEFAULT;

  typedef struct {
    logic [INDEX_BITS-1:0]  first_index;
    logic [INDEX_BITS-1:0]  second_index;
    logic [INDEX_BITS-1:0]  third_index;
    logic [VERTEX_BITS-1:0] first_vertex;
    logic [VERTEX_BITS-1:0] second_vertex;
    logic [VERTEX_BITS-1:0] third_vertex;
    logic                   mesh_last;
  } tri_word_t;

  typedef struct {
    verdict_t              verdict;
    logic [INDEX_BITS-1:0] first_index;
    logic [INDEX_BITS-1:0] second_index;
    logic [INDEX_BITS-1:0] third_index;
    logic                  mesh_end;
  } verdict_word_t;

  class cull_scoreboard;
    logic [INDEX_BITS-1:0]       vertex_count;
    logic [PLANE_COUNT_BITS-1:0] plane_count;
    logic [CFG_DATA_BITS-1:0]    plane_coeffs [PLANES];
    verdict_word_t               awaited_q [$];
    int                          errors;
    int                          checked;
    int                          tally [3];

    function new();
      vertex_count = '0;
      plane_count  = PLANE_COUNT_RESET;
      foreach (plane_coeffs[k]) plane_coeffs[k] = '0;
      errors  = 0;
      checked = 0;
      foreach (tally[k]) tally[k] = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_VERTEX_COUNT) begin
        vertex_count = data[INDEX_BITS-1:0];
      end else if (idx == REG_PLANE_COUNT) begin
        plane_count = data[PLANE_COUNT_BITS-1:0];
      end else if (idx >= REG_PLANE_BASE && int'(idx - REG_PLANE_BASE) < PLANES) begin
        plane_coeffs[idx - REG_PLANE_BASE] = data;
      end
    endfunction

    function bit corner_outside(logic [CFG_DATA_BITS-1:0] pl, logic [VERTEX_BITS-1:0] v);
      longint a, b, c, d, x, y, z, distance;
      a = $signed(pl[63:48]);
      b = $signed(pl[47:32]);
      c = $signed(pl[31:16]);
      d = $signed(pl[15:0]);
      x = $signed(v[2*CB +: CB]);
      y = $signed(v[CB +: CB]);
      z = $signed(v[0 +: CB]);
      distance = a * x + b * y + c * z + (d <<< OFFSET_SHIFT);
      return distance < 0;
    endfunction

    function verdict_t classify(tri_word_t w);
      int tested;
      tested = (plane_count > PLANES) ? PLANES : int'(plane_count);
      if (w.first_index >= vertex_count || w.second_index >= vertex_count ||
          w.third_index >= vertex_count)
        return VERDICT_SKIPPED;
      for (int p = 0; p < tested; p++) begin
        if (corner_outside(plane_coeffs[p], w.first_vertex) &&
            corner_outside(plane_coeffs[p], w.second_vertex) &&
            corner_outside(plane_coeffs[p], w.third_vertex))
          return VERDICT_CULLED;
      end
      return VERDICT_VISIBLE;
    endfunction

    function void note_triangle(tri_word_t w);
      verdict_word_t e;
      e.verdict = classify(w);
      e.first_index  = (e.verdict == VERDICT_VISIBLE) ? w.first_index  : '0;
      e.second_index = (e.verdict == VERDICT_VISIBLE) ? w.second_index : '0;
      e.third_index  = (e.verdict == VERDICT_VISIBLE) ? w.third_index  : '0;
      e.mesh_end = w.mesh_last;
      awaited_q = {awaited_q, e};
    endfunction

    function void check_verdict(verdict_word_t got);
      verdict_word_t e;
      if (awaited_q.size() == 0) begin
        $error("result word with no triangle outstanding: verdict %0d", got.verdict);
        errors++;
        return;
      end
      e = awaited_q.pop_front();
      checked++;
      tally[e.verdict]++;
      if (got.verdict !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, got.verdict);
        errors++;
      end
      if (got.first_index !== e.first_index) begin
        $error("out_first_index: expected %h, got %h", e.first_index, got.first_index);
        errors++;
      end
      if (got.second_index !== e.second_index) begin
        $error("out_second_index: expected %h, got %h", e.second_index, got.second_index);
        errors++;
      end
      if (got.third_index !== e.third_index) begin
        $error("out_third_index: expected %h, got %h", e.third_index, got.third_index);
        errors++;
      end
      if (got.mesh_end !== e.mesh_end) begin
        $error("mesh_end: expected %b, got %b", e.mesh_end, got.mesh_end);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  bit                        steady;
  int                        settings_used;
  logic [CFG_DATA_BITS-1:0]  plane_set [PLANES];
  verdict_word_t             res_word;
  cull_scoreboard            sb = new();

  tfc_tri_if tri_ch ();
  tfc_res_if res_ch ();

  triangle_frustum_cull DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tri_in    (tri_ch),
    .res_out   (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_word.verdict      = res_ch.verdict;
      res_word.first_index  = res_ch.out_first_index;
      res_word.second_index = res_ch.out_second_index;
      res_word.third_index  = res_ch.out_third_index;
      res_word.mesh_end     = res_ch.mesh_end;
      sb.check_verdict(res_word);
    end
    res_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  function automatic logic [VERTEX_BITS-1:0] mk_vertex(logic [15:0] x, logic [15:0] y,
                                                       logic [15:0] z);
    return {x, y, z};
  endfunction

  function automatic tri_word_t mk_tri(logic [31:0] i0, logic [31:0] i1, logic [31:0] i2,
                                       logic [47:0] v0, logic [47:0] v1, logic [47:0] v2,
                                       logic last);
    tri_word_t w;
    w.first_index   = i0;
    w.second_index  = i1;
    w.third_index   = i2;
    w.first_vertex  = v0;
    w.second_vertex = v1;
    w.third_vertex  = v2;
    w.mesh_last     = last;
    return w;
  endfunction

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(1) == 1)
      return 16'($urandom);
    return 16'($urandom_range(2047)) - 16'd1024;
  endfunction

  function automatic logic [VERTEX_BITS-1:0] rand_vertex();
    return mk_vertex(rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic logic [31:0] rand_index(logic [31:0] count);
    if (count != 0 && $urandom_range(99) < 85)
      return $urandom_range(count - 1, 0);
    return $urandom_range(32'hFFFF_FFFF, count);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic configure(logic [31:0] count, logic [2:0] planes_on);
    write_reg(REG_VERTEX_COUNT, {32'($urandom), count});
    write_reg(REG_PLANE_COUNT, {61'({$urandom, $urandom}), planes_on});
    for (int k = 0; k < PLANES; k++)
      write_reg(REG_PLANE_BASE + CFG_INDEX_BITS'(k), plane_set[k]);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tri(tri_word_t w);
    while (!steady && $urandom_range(99) < 31) begin
      tri_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tri_ch.valid         <= 1'b1;
    tri_ch.first_index   <= w.first_index;
    tri_ch.second_index  <= w.second_index;
    tri_ch.third_index   <= w.third_index;
    tri_ch.first_vertex  <= w.first_vertex;
    tri_ch.second_vertex <= w.second_vertex;
    tri_ch.third_vertex  <= w.third_vertex;
    tri_ch.mesh_last     <= w.mesh_last;
    do @(posedge clk); while (!tri_ch.ready);
    sb.note_triangle(w);
  endtask

  task automatic wait_all_returned();
    tri_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [47:0] on_edge, just_out, far_in, top_x, low_z;
    logic [31:0] count;
    logic [2:0]  planes_on;

    rst = 1'b1;
    steady = 1'b0;
    settings_used = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tri_ch.valid = 1'b0;
    tri_ch.first_index = '0;
    tri_ch.second_index = '0;
    tri_ch.third_index = '0;
    tri_ch.first_vertex = '0;
    tri_ch.second_vertex = '0;
    tri_ch.third_vertex = '0;
    tri_ch.mesh_last = 1'b0;
    res_ch.ready = 1'b0;

    on_edge  = mk_vertex(16'h0100, 16'h0000, 16'h0000);
    just_out = mk_vertex(16'h00FF, 16'h0000, 16'h0000);
    far_in   = mk_vertex(16'h0200, 16'h0000, 16'h0000);
    top_x    = mk_vertex(16'h7FFF, 16'h8000, 16'h8000);
    low_z    = mk_vertex(16'h1000, 16'h8000, 16'h8000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset the vertex count is zero, so every triangle is skipped.
    send_tri(mk_tri(0, 0, 0, on_edge, on_edge, on_edge, 1'b1));
    wait_all_returned();

    // Plane 0 keeps x >= 1.0, plane 1 x < 64.0, plane 2 z >= -64.0; plane 3 is
    // all zero, plane 4 never clips and plane 5 clips everything.
    plane_set[0] = {16'h4000, 16'h0000, 16'h0000, 16'hFF00};
    plane_set[1] = {16'h8000, 16'h0000, 16'h0000, 16'h7FFF};
    plane_set[2] = {16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF};
    plane_set[3] = '0;
    plane_set[4] = {16'h0000, 16'h0000, 16'h0000, 16'h0001};
    plane_set[5] = {16'h0000, 16'h0000, 16'h0000, 16'h8000};
    configure(32'd16, 3'd5);
    send_tri(mk_tri(1, 2, 3, on_edge, on_edge, on_edge, 1'b0));
    send_tri(mk_tri(4, 5, 6, just_out, just_out, just_out, 1'b0));
    send_tri(mk_tri(7, 8, 9, just_out, just_out, far_in, 1'b0));
    send_tri(mk_tri(1, 1, 1, mk_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    mk_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    mk_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0));
    send_tri(mk_tri(2, 3, 4, top_x, top_x, mk_vertex(16'h1000, 16'h8000, 16'h0000), 1'b0));
    send_tri(mk_tri(5, 6, 7, low_z, low_z, low_z, 1'b0));
    send_tri(mk_tri(15, 15, 15, on_edge, on_edge, on_edge, 1'b1));
    send_tri(mk_tri(16, 0, 0, on_edge, on_edge, on_edge, 1'b0));
    send_tri(mk_tri(0, 16, 0, on_edge, on_edge, on_edge, 1'b0));
    send_tri(mk_tri(0, 0, 32'hFFFF_FFFF, on_edge, on_edge, on_edge, 1'b1));
    wait_all_returned();

    // A plane count above the slot count tests all six planes.
    configure(32'd16, 3'd7);
    send_tri(mk_tri(1, 2, 3, on_edge, on_edge, on_edge, 1'b0));
    send_tri(mk_tri(7, 8, 9, just_out, just_out, far_in, 1'b0));
    wait_all_returned();
    configure(32'd16, 3'd6);
    send_tri(mk_tri(1, 2, 3, on_edge, on_edge, on_edge, 1'b1));
    wait_all_returned();

    // No planes: every triangle with good indices is visible.
    configure(32'hFFFF_FFFF, 3'd0);
    send_tri(mk_tri(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                    just_out, just_out, just_out, 1'b0));
    send_tri(mk_tri(32'hFFFF_FFFF, 0, 1, just_out, just_out, just_out, 1'b0));
    send_tri(mk_tri(0, 0, 0, low_z, low_z, low_z, 1'b1));
    wait_all_returned();

    for (int setting = 0; setting < 7; setting++) begin
      case (setting)
        0: begin count = 32'd1000;                   planes_on = 3'd6;                end
        1: begin count = 32'hFFFF_FFFF;              planes_on = 3'd7;                end
        2: begin count = $urandom;                   planes_on = 3'($urandom_range(7)); end
        3: begin count = 32'd1;                      planes_on = 3'd1;                end
        4: begin count = 32'h8000_0000;              planes_on = 3'd3;                end
        5: begin count = $urandom_range(200, 1);     planes_on = 3'($urandom_range(7)); end
        default: begin count = 32'hFFFF_FFFF;        planes_on = 3'd6;                end
      endcase
      foreach (plane_set[k]) plane_set[k] = {$urandom, $urandom};
      configure(count, planes_on);
      steady = (setting == 2);
      for (int n = 0; n < 86; n++) begin
        if (setting == 3 && n == 40)
          wait_all_returned();
        send_tri(mk_tri(rand_index(count), rand_index(count), rand_index(count),
                        rand_vertex(), rand_vertex(), rand_vertex(),
                        1'($urandom_range(7) == 0)));
      end
      wait_all_returned();
      steady = 1'b0;
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d triangles under %0d register settings:", sb.checked, settings_used);
    $display("%0d visible, %0d skipped for bad indices, %0d culled by a plane.",
             sb.tally[VERDICT_VISIBLE], sb.tally[VERDICT_SKIPPED], sb.tally[VERDICT_CULLED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
